/* hdl/assert_macros.svh */
// Assertion macros shared by the magnet iteration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/mfi_pkg.sv */
// Shared types, constants and saturating fixed-point functions.
package mfi_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 24;
    localparam int DIV_BITS      = WORD_BITS + FRACTION_BITS;

    // Queue between front and back
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;
    localparam logic [Q_AW:0] Q_CNT_FULL = Q_DEPTH[Q_AW:0];

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_mag;
    typedef logic [2*WORD_BITS-1:0]      t_wide;

    // Value with its own saturation history
    typedef struct packed {
        logic  sat;
        t_word v;
    } t_sw;

    localparam t_word WMAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WMIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ONE_V = {{(WORD_BITS-FRACTION_BITS-1){1'b0}}, 1'b1,
                               {FRACTION_BITS{1'b0}}};
    localparam t_word TWO_V = {{(WORD_BITS-FRACTION_BITS-2){1'b0}}, 1'b1,
                               {(FRACTION_BITS+1){1'b0}}};
    localparam t_sw Q_ONE = '{sat: 1'b0, v: ONE_V};
    localparam t_sw Q_TWO = '{sat: 1'b0, v: TWO_V};

    // Queue entry: what the back end needs for the complex division
    typedef struct packed {
        t_sw  div;
        t_sw  nre;
        t_sw  nim;
        logic degen;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_mag f_mag(t_word a);
        return a[WORD_BITS-1] ? t_mag'(-a) : t_mag'(a);
    endfunction

    // Sign and magnitude to word, saturating
    function automatic t_sw f_sat(logic neg, t_wide mag);
        t_sw   r;
        t_wide lim;
        lim = '0;
        lim[WORD_BITS-1] = 1'b1;
        if (!neg) lim = lim - 1'b1;
        if (mag > lim) begin
            r.sat = 1'b1;
            r.v   = neg ? WMIN : WMAX;
        end else begin
            r.sat = 1'b0;
            r.v   = neg ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sw f_add(t_sw a, t_sw b);
        t_sw r;
        logic [WORD_BITS:0] s;
        s = {a.v[WORD_BITS-1], a.v} + {b.v[WORD_BITS-1], b.v};
        r.sat = a.sat | b.sat;
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r.sat = 1'b1;
            r.v   = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            r.v = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sw f_sub(t_sw a, t_sw b);
        t_sw r;
        logic [WORD_BITS:0] s;
        s = {a.v[WORD_BITS-1], a.v} - {b.v[WORD_BITS-1], b.v};
        r.sat = a.sat | b.sat;
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r.sat = 1'b1;
            r.v   = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            r.v = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sw f_tri(t_sw a);
        return f_add(f_add(a, a), a);
    endfunction

    // Product rounded half away from zero, saturating
    function automatic t_sw f_mul(t_sw a, t_sw b);
        t_sw   r;
        t_wide p;
        t_wide rnd;
        t_mag  ma;
        t_mag  mb;
        ma  = f_mag(a.v);
        mb  = f_mag(b.v);
        rnd = '0;
        rnd[FRACTION_BITS-1] = 1'b1;
        p = t_wide'(ma) * t_wide'(mb);
        p = p + rnd;
        r = f_sat(a.v[WORD_BITS-1] ^ b.v[WORD_BITS-1], p >> FRACTION_BITS);
        r.sat = r.sat | a.sat | b.sat;
        return r;
    endfunction

endpackage

/* hdl/mfi_channels.sv */
// Handshake channel interfaces: input item, result item, config write.
interface mfi_item_if;
    logic          valid;
    logic          ready;
    mfi_pkg::t_word z_re;
    mfi_pkg::t_word z_im;
    mfi_pkg::t_word c_re;
    mfi_pkg::t_word c_im;
    modport source (output valid, z_re, z_im, c_re, c_im, input ready);
    modport sink   (input valid, z_re, z_im, c_re, c_im, output ready);
endinterface

interface mfi_res_if;
    logic          valid;
    logic          ready;
    mfi_pkg::t_word next_re;
    mfi_pkg::t_word next_im;
    logic          degenerate;
    logic          overflowed;
    modport source (output valid, next_re, next_im, degenerate, overflowed, input ready);
    modport sink   (input valid, next_re, next_im, degenerate, overflowed, output ready);
endinterface

interface mfi_cfg_if;
    logic valid;
    logic ready;
    logic formula_select;
    modport source (output valid, formula_select, input ready);
    modport sink   (input valid, formula_select, output ready);
endinterface

/* hdl/mfi_front.sv */
// Front end: accepts items, builds numerator/denominator, classifies degenerate.
module mfi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mfi_item_if.sink         i_item,
    input  logic             i_fsel,
    input  mfi_pkg::t_qstat  i_qstat,
    output logic             o_push,
    output mfi_pkg::t_qent   o_entry
);

    typedef struct packed {
        logic f;
        mfi_pkg::t_sw x, y, a, b, m1r, m2r, sx, sy, xy, bb, t1i;
    } t_s1;

    typedef struct packed {
        logic f;
        mfi_pkg::t_sw x, y, sx, sy, bb, t1i, p1, p2, p3, t1r, t2r, sd, v1, d;
        mfi_pkg::t_sw tre1, tim1, bre1, bim1;
    } t_s2;

    typedef struct packed {
        logic f;
        mfi_pkg::t_sw x, y, pr, pi, u2, v2, w, td, q1, q2, q3, q4;
        mfi_pkg::t_sw tre1, tim1, bre1, bim1;
    } t_s3;

    typedef struct packed {
        logic f;
        mfi_pkg::t_sw pr, pi, q2, q3, r1, r2, brea, bima;
        mfi_pkg::t_sw tre1, tim1, bre1, bim1;
    } t_s4;

    typedef struct packed {
        mfi_pkg::t_sw tre, tim, bre, bim;
    } t_s5;

    typedef struct packed {
        mfi_pkg::t_sw pa, pb, pc, pd, pe, pf;
    } t_s6;

    logic [6:0]      r_v;
    logic            w_en;
    t_s1             r_s1, n_s1;
    t_s2             r_s2, n_s2;
    t_s3             r_s3, n_s3;
    t_s4             r_s4, n_s4;
    t_s5             r_s5, n_s5;
    t_s6             r_s6, n_s6;
    mfi_pkg::t_qent  r_s7, n_s7;

    // Whole pipeline moves unless the last stage is stuck on a full queue
    assign w_en         = ~r_v[6] | ~i_qstat.full;
    assign i_item.ready = w_en;
    assign o_push       = r_v[6] & ~i_qstat.full;
    assign o_entry      = r_s7;

    // Stage 1: squares of z, c offsets
    always_comb begin
        n_s1.f   = i_fsel;
        n_s1.x   = '{sat: 1'b0, v: i_item.z_re};
        n_s1.y   = '{sat: 1'b0, v: i_item.z_im};
        n_s1.a   = '{sat: 1'b0, v: i_item.c_re};
        n_s1.b   = '{sat: 1'b0, v: i_item.c_im};
        n_s1.m1r = mfi_pkg::f_sub(n_s1.a, mfi_pkg::Q_ONE);
        n_s1.m2r = mfi_pkg::f_sub(n_s1.a, mfi_pkg::Q_TWO);
        n_s1.sx  = mfi_pkg::f_mul(n_s1.x, n_s1.x);
        n_s1.sy  = mfi_pkg::f_mul(n_s1.y, n_s1.y);
        n_s1.xy  = mfi_pkg::f_mul(n_s1.x, n_s1.y);
        n_s1.bb  = mfi_pkg::f_mul(n_s1.b, n_s1.b);
        n_s1.t1i = mfi_pkg::f_tri(n_s1.b);
    end

    // Stage 2: c products, triples; formula 1 terms complete
    always_comb begin
        n_s2.f    = r_s1.f;
        n_s2.x    = r_s1.x;
        n_s2.y    = r_s1.y;
        n_s2.sx   = r_s1.sx;
        n_s2.sy   = r_s1.sy;
        n_s2.bb   = r_s1.bb;
        n_s2.t1i  = r_s1.t1i;
        n_s2.p1   = mfi_pkg::f_mul(r_s1.m1r, r_s1.m2r);
        n_s2.p2   = mfi_pkg::f_mul(r_s1.m1r, r_s1.b);
        n_s2.p3   = mfi_pkg::f_mul(r_s1.b, r_s1.m2r);
        n_s2.t1r  = mfi_pkg::f_tri(r_s1.m1r);
        n_s2.t2r  = mfi_pkg::f_tri(r_s1.m2r);
        n_s2.sd   = mfi_pkg::f_sub(r_s1.sx, r_s1.sy);
        n_s2.v1   = mfi_pkg::f_add(r_s1.sx, r_s1.sx);
        n_s2.d    = mfi_pkg::f_add(r_s1.xy, r_s1.xy);
        n_s2.tre1 = mfi_pkg::f_sub(mfi_pkg::f_add(mfi_pkg::f_sub(r_s1.sx, r_s1.sy), r_s1.a),
                                   mfi_pkg::Q_ONE);
        n_s2.tim1 = mfi_pkg::f_add(mfi_pkg::f_add(r_s1.xy, r_s1.xy), r_s1.b);
        n_s2.bre1 = mfi_pkg::f_sub(mfi_pkg::f_add(mfi_pkg::f_add(r_s1.x, r_s1.x), r_s1.a),
                                   mfi_pkg::Q_TWO);
        n_s2.bim1 = mfi_pkg::f_add(mfi_pkg::f_add(r_s1.y, r_s1.y), r_s1.b);
    end

    // Stage 3: (c-1)(c-2), polynomial brackets, z times c triples
    always_comb begin
        n_s3.f    = r_s2.f;
        n_s3.x    = r_s2.x;
        n_s3.y    = r_s2.y;
        n_s3.pr   = mfi_pkg::f_sub(r_s2.p1, r_s2.bb);
        n_s3.pi   = mfi_pkg::f_add(r_s2.p2, r_s2.p3);
        n_s3.u2   = mfi_pkg::f_add(mfi_pkg::f_sub(mfi_pkg::f_sub(r_s2.sd, r_s2.sy), r_s2.sy),
                                   r_s2.t1r);
        n_s3.v2   = mfi_pkg::f_add(mfi_pkg::f_sub(mfi_pkg::f_add(r_s2.v1, r_s2.sx), r_s2.sy),
                                   r_s2.t1r);
        n_s3.w    = mfi_pkg::f_tri(r_s2.sd);
        n_s3.td   = mfi_pkg::f_tri(r_s2.d);
        n_s3.q1   = mfi_pkg::f_mul(r_s2.x, r_s2.t2r);
        n_s3.q2   = mfi_pkg::f_mul(r_s2.y, r_s2.t1i);
        n_s3.q3   = mfi_pkg::f_mul(r_s2.x, r_s2.t1i);
        n_s3.q4   = mfi_pkg::f_mul(r_s2.y, r_s2.t2r);
        n_s3.tre1 = r_s2.tre1;
        n_s3.tim1 = r_s2.tim1;
        n_s3.bre1 = r_s2.bre1;
        n_s3.bim1 = r_s2.bim1;
    end

    // Stage 4: cubic products, partial denominator sums
    always_comb begin
        n_s4.f    = r_s3.f;
        n_s4.pr   = r_s3.pr;
        n_s4.pi   = r_s3.pi;
        n_s4.q2   = r_s3.q2;
        n_s4.q3   = r_s3.q3;
        n_s4.r1   = mfi_pkg::f_mul(r_s3.x, r_s3.u2);
        n_s4.r2   = mfi_pkg::f_mul(r_s3.y, r_s3.v2);
        n_s4.brea = mfi_pkg::f_sub(mfi_pkg::f_add(r_s3.w, r_s3.q1), r_s3.q2);
        n_s4.bima = mfi_pkg::f_add(mfi_pkg::f_add(r_s3.td, r_s3.q3), r_s3.q4);
        n_s4.tre1 = r_s3.tre1;
        n_s4.tim1 = r_s3.tim1;
        n_s4.bre1 = r_s3.bre1;
        n_s4.bim1 = r_s3.bim1;
    end

    // Stage 5: finish formula 2 and pick the formula
    always_comb begin
        if (r_s4.f) begin
            n_s5.tre = mfi_pkg::f_add(mfi_pkg::f_sub(r_s4.r1, r_s4.q2), r_s4.pr);
            n_s5.tim = mfi_pkg::f_add(mfi_pkg::f_add(r_s4.r2, r_s4.q3), r_s4.pi);
            n_s5.bre = mfi_pkg::f_add(mfi_pkg::f_add(r_s4.brea, r_s4.pr), mfi_pkg::Q_ONE);
            n_s5.bim = mfi_pkg::f_add(r_s4.bima, r_s4.pi);
        end else begin
            n_s5.tre = r_s4.tre1;
            n_s5.tim = r_s4.tim1;
            n_s5.bre = r_s4.bre1;
            n_s5.bim = r_s4.bim1;
        end
    end

    // Stage 6: products for top * conj(bot) and |bot|^2
    always_comb begin
        n_s6.pa = mfi_pkg::f_mul(r_s5.bre, r_s5.bre);
        n_s6.pb = mfi_pkg::f_mul(r_s5.bim, r_s5.bim);
        n_s6.pc = mfi_pkg::f_mul(r_s5.tre, r_s5.bre);
        n_s6.pd = mfi_pkg::f_mul(r_s5.tim, r_s5.bim);
        n_s6.pe = mfi_pkg::f_mul(r_s5.tim, r_s5.bre);
        n_s6.pf = mfi_pkg::f_mul(r_s5.tre, r_s5.bim);
    end

    // Stage 7: sums and degenerate check
    always_comb begin
        n_s7.div   = mfi_pkg::f_add(r_s6.pa, r_s6.pb);
        n_s7.nre   = mfi_pkg::f_add(r_s6.pc, r_s6.pd);
        n_s7.nim   = mfi_pkg::f_sub(r_s6.pe, r_s6.pf);
        n_s7.degen = (n_s7.div.v == '0) | n_s7.div.v[mfi_pkg::WORD_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[5:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
        end
    end

endmodule

/* hdl/mfi_fifo.sv */
// Short queue decoupling the front end from the division back end.
module mfi_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfi_pkg::t_qent   i_entry,
    input  logic             i_pop,
    output mfi_pkg::t_qent   o_head,
    output mfi_pkg::t_qstat  o_qstat
);

    mfi_pkg::t_qent            r_mem [mfi_pkg::Q_DEPTH];
    logic [mfi_pkg::Q_AW-1:0]  r_wp;
    logic [mfi_pkg::Q_AW-1:0]  r_rp;
    logic [mfi_pkg::Q_AW:0]    r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == mfi_pkg::Q_CNT_FULL);
    assign o_qstat.empty = (r_cnt == '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/mfi_back.sv */
// Back end: pipelined restoring divider, final squaring, output register.
module mfi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfi_pkg::t_qstat  i_qstat,
    input  mfi_pkg::t_qent   i_head,
    output logic             o_pop,
    mfi_res_if.source        o_result
);

    localparam int W  = mfi_pkg::WORD_BITS;
    localparam int DB = mfi_pkg::DIV_BITS;

    // One divider lane: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [W-2:0]  rem;
        logic [DB-1:0] dq;
    } t_dch;

    typedef struct packed {
        logic         degen;
        logic [W-2:0] d;
        logic         sat_re;
        logic         sat_im;
        logic         neg_re;
        logic         neg_im;
        t_dch         re;
        t_dch         im;
    } t_dst;

    typedef struct packed {
        logic         degen;
        mfi_pkg::t_sw tr;
        mfi_pkg::t_sw ti;
    } t_b1;

    typedef struct packed {
        logic         degen;
        mfi_pkg::t_sw s;
        mfi_pkg::t_sw df;
        mfi_pkg::t_sw n0;
    } t_b2;

    typedef struct packed {
        mfi_pkg::t_word next_re;
        mfi_pkg::t_word next_im;
        logic           degen;
        logic           ovf;
    } t_out;

    function automatic t_dch f_dbit(t_dch c, logic [W-2:0] d);
        t_dch       r;
        logic [W-1:0] t;
        logic [W-1:0] diff;
        t    = {c.rem, c.dq[DB-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r.rem = diff[W-2:0];
            r.dq  = {c.dq[DB-2:0], 1'b1};
        end else begin
            r.rem = t[W-2:0];
            r.dq  = {c.dq[DB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dst f_dstep(t_dst s);
        t_dst r;
        r    = s;
        r.re = f_dbit(s.re, s.d);
        r.im = f_dbit(s.im, s.d);
        return r;
    endfunction

    logic          w_en;
    logic [DB-1:0] r_dv;
    t_dst          r_ds [DB];
    t_dst          w_init;
    logic          r_b1v;
    logic          r_b2v;
    logic          r_ov;
    t_b1           r_b1, n_b1;
    t_b2           r_b2, n_b2;
    t_out          r_out, n_out;
    mfi_pkg::t_sw  w_nr;
    mfi_pkg::t_sw  w_ni;

    // Every stage moves when the output register is free or being taken
    assign w_en  = ~r_ov | o_result.ready;
    assign o_pop = w_en & ~i_qstat.empty;

    // Divider setup: |numerator| << FRACTION_BITS over the positive divisor
    always_comb begin
        w_init.degen  = i_head.degen;
        w_init.d      = i_head.div.v[W-2:0];
        w_init.sat_re = i_head.nre.sat | i_head.div.sat;
        w_init.sat_im = i_head.nim.sat | i_head.div.sat;
        w_init.neg_re = i_head.nre.v[W-1];
        w_init.neg_im = i_head.nim.v[W-1];
        w_init.re.rem = '0;
        w_init.im.rem = '0;
        w_init.re.dq  = {mfi_pkg::f_mag(i_head.nre.v), {mfi_pkg::FRACTION_BITS{1'b0}}};
        w_init.im.dq  = {mfi_pkg::f_mag(i_head.nim.v), {mfi_pkg::FRACTION_BITS{1'b0}}};
    end

    // Divider: one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (w_en) r_ds[0] <= f_dstep(w_init);
    end

    for (genvar k = 1; k < DB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) r_ds[k] <= f_dstep(r_ds[k-1]);
        end
    end

    // Quotients to words with saturation
    always_comb begin
        n_b1.degen = r_ds[DB-1].degen;
        n_b1.tr    = mfi_pkg::f_sat(r_ds[DB-1].neg_re,
                         {{(2*W-DB){1'b0}}, r_ds[DB-1].re.dq});
        n_b1.ti    = mfi_pkg::f_sat(r_ds[DB-1].neg_im,
                         {{(2*W-DB){1'b0}}, r_ds[DB-1].im.dq});
        n_b1.tr.sat = n_b1.tr.sat | r_ds[DB-1].sat_re;
        n_b1.ti.sat = n_b1.ti.sat | r_ds[DB-1].sat_im;
    end

    // Square of the quotient, first half
    always_comb begin
        n_b2.degen = r_b1.degen;
        n_b2.s     = mfi_pkg::f_add(r_b1.tr, r_b1.ti);
        n_b2.df    = mfi_pkg::f_sub(r_b1.tr, r_b1.ti);
        n_b2.n0    = mfi_pkg::f_mul(r_b1.tr, r_b1.ti);
    end

    // Square of the quotient, second half, and result forming
    always_comb begin
        w_nr = mfi_pkg::f_mul(r_b2.s, r_b2.df);
        w_ni = mfi_pkg::f_add(r_b2.n0, r_b2.n0);
        if (r_b2.degen) begin
            n_out.next_re = '0;
            n_out.next_im = '0;
            n_out.degen   = 1'b1;
            n_out.ovf     = 1'b0;
        end else begin
            n_out.next_re = w_nr.v;
            n_out.next_im = w_ni.v;
            n_out.degen   = 1'b0;
            n_out.ovf     = w_nr.sat | w_ni.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1  <= n_b1;
            r_b2  <= n_b2;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv  <= '0;
            r_b1v <= 1'b0;
            r_b2v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_dv  <= {r_dv[DB-2:0], o_pop};
            r_b1v <= r_dv[DB-1];
            r_b2v <= r_b1v;
            r_ov  <= r_b2v;
        end
    end

    assign o_result.valid      = r_ov;
    assign o_result.next_re    = r_out.next_re;
    assign o_result.next_im    = r_out.next_im;
    assign o_result.degenerate = r_out.degen;
    assign o_result.overflowed = r_out.ovf;

endmodule

/* hdl/magnet_fractal_iteration_step_top.sv */
// Top level of the magnet fractal iteration step.
// Path from item acceptance to result valid: 7 front stages, the queue,
// 56 divider stages, 3 squaring/output stages.
// Throughput: one item per cycle while results are taken; the 56-stage bit-per-stage divider sets the depth.
// Reset (synchronous, active low) empties all stages and the queue, formula_select = 0.
`include "assert_macros.svh"

module magnet_fractal_iteration_step_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfi_item_if.sink  i_item,
    mfi_cfg_if.sink   i_cfg,
    mfi_res_if.source o_result
);

    logic             r_fsel;
    logic             w_push;
    logic             w_pop;
    mfi_pkg::t_qent   w_entry;
    mfi_pkg::t_qent   w_head;
    mfi_pkg::t_qstat  w_qstat;

    // Formula select register; writes always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel <= 1'b0;
        end else if (i_cfg.valid) begin
            r_fsel <= i_cfg.formula_select;
        end
    end

    mfi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_fsel  (r_fsel),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    mfi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    mfi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    // Checks
    `ASSERT_SAME(a_degen_zero, i_clk, i_rst_n, o_result.valid && o_result.degenerate, o_result.next_re == '0 && o_result.next_im == '0 && !o_result.overflowed)
    `ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, w_push, !w_qstat.full)
    `ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    `ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg.valid && i_cfg.ready, r_fsel == $past(i_cfg.formula_select))

endmodule

/* verif/magnet_fractal_iteration_step_checker.sv */
// Checker for the magnet iteration step: watches the channels, predicts each result, compares.
`timescale 1ns / 100ps

module magnet_fractal_iteration_step_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mfi_item_if   item_mon,
    mfi_cfg_if    cfg_mon,
    mfi_res_if    res_mon,
    output int    o_mismatches,
    output int    o_pending
);

    typedef struct {
        mfi_pkg::t_word next_re;
        mfi_pkg::t_word next_im;
        logic           degenerate;
        logic           overflowed;
    } t_iter_result;

    localparam longint SMAX = (64'sd1 <<< (mfi_pkg::WORD_BITS - 1)) - 1;
    localparam longint SMIN = -(64'sd1 <<< (mfi_pkg::WORD_BITS - 1));
    localparam longint QONE = 64'sd1 <<< mfi_pkg::FRACTION_BITS;
    localparam longint QTWO = 64'sd1 <<< (mfi_pkg::FRACTION_BITS + 1);

    t_iter_result expected_steps[$];
    logic         formula_sel;
    bit           sat_hit;
    int           mismatches;

    assign o_mismatches = mismatches;
    assign o_pending    = expected_steps.size();

    function automatic longint clamp_mag(bit neg, longint unsigned mag);
        longint unsigned lim;
        lim = neg ? longint'(64'd1 << (mfi_pkg::WORD_BITS - 1)) : SMAX;
        if (mag > lim) begin
            sat_hit = 1'b1;
            return neg ? SMIN : SMAX;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned abs_of(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint sadd(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SMAX) begin sat_hit = 1'b1; return SMAX; end
        if (s < SMIN) begin sat_hit = 1'b1; return SMIN; end
        return s;
    endfunction

    function automatic longint ssub(longint a, longint b);
        longint s;
        s = a - b;
        if (s > SMAX) begin sat_hit = 1'b1; return SMAX; end
        if (s < SMIN) begin sat_hit = 1'b1; return SMIN; end
        return s;
    endfunction

    // product rounded half away from zero
    function automatic longint smul(longint a, longint b);
        longint unsigned p;
        p = abs_of(a) * abs_of(b) + (64'd1 << (mfi_pkg::FRACTION_BITS - 1));
        return clamp_mag((a < 0) != (b < 0), p >> mfi_pkg::FRACTION_BITS);
    endfunction

    // quotient truncated toward zero, divisor positive
    function automatic longint sdiv(longint n, longint d);
        longint unsigned q;
        q = (abs_of(n) << mfi_pkg::FRACTION_BITS) / longint'(d);
        return clamp_mag(n < 0, q);
    endfunction

    function automatic longint stri(longint a);
        return sadd(sadd(a, a), a);
    endfunction

    function automatic t_iter_result predict_step(mfi_pkg::t_word zr, mfi_pkg::t_word zi,
                                                  mfi_pkg::t_word cr, mfi_pkg::t_word ci,
                                                  logic sel);
        t_iter_result r;
        longint x, y, a, b, sx, sy, xy, m1, m2, pr, pi, t1r, t1i, t2r, t2i, d;
        longint top_re, top_im, bot_re, bot_im, dv, tr, ti, nr, ni;
        x = zr; y = zi; a = cr; b = ci;
        sat_hit = 1'b0;
        sx = smul(x, x);
        sy = smul(y, y);
        if (!sel) begin
            xy     = smul(x, y);
            top_re = ssub(sadd(ssub(sx, sy), a), QONE);
            top_im = sadd(sadd(xy, xy), b);
            bot_re = ssub(sadd(sadd(x, x), a), QTWO);
            bot_im = sadd(sadd(y, y), b);
        end else begin
            // cubic-over-quadratic form, c terms computed per item
            m1  = ssub(a, QONE);
            m2  = ssub(a, QTWO);
            pr  = ssub(smul(m1, m2), smul(b, b));
            pi  = sadd(smul(m1, b), smul(b, m2));
            t1r = stri(m1); t1i = stri(b); t2r = stri(m2); t2i = stri(b);
            top_re = sadd(ssub(smul(x, sadd(ssub(ssub(ssub(sx, sy), sy), sy), t1r)),
                               smul(y, t1i)), pr);
            top_im = sadd(sadd(smul(y, sadd(ssub(sadd(sadd(sx, sx), sx), sy), t1r)),
                               smul(x, t1i)), pi);
            bot_re = sadd(sadd(ssub(sadd(stri(ssub(sx, sy)), smul(x, t2r)), smul(y, t2i)),
                               pr), QONE);
            xy     = smul(x, y);
            d      = sadd(xy, xy);
            bot_im = sadd(sadd(sadd(stri(d), smul(x, t2i)), smul(y, t2r)), pi);
        end
        dv = sadd(smul(bot_re, bot_re), smul(bot_im, bot_im));
        if (dv <= 0) begin
            r = '{next_re: '0, next_im: '0, degenerate: 1'b1, overflowed: 1'b0};
            return r;
        end
        tr = sdiv(sadd(smul(top_re, bot_re), smul(top_im, bot_im)), dv);
        ti = sdiv(ssub(smul(top_im, bot_re), smul(top_re, bot_im)), dv);
        nr = smul(sadd(tr, ti), ssub(tr, ti));
        ni = smul(tr, ti);
        ni = sadd(ni, ni);
        r.next_re    = mfi_pkg::t_word'(nr);
        r.next_im    = mfi_pkg::t_word'(ni);
        r.degenerate = 1'b0;
        r.overflowed = sat_hit;
        return r;
    endfunction

    // watch config writes, accepted items and results
    always @(posedge i_clk) begin
        t_iter_result exp_r;
        if (!i_rst_n) begin
            formula_sel = 1'b0;
            expected_steps.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready)
                formula_sel = cfg_mon.formula_select;
            if (item_mon.valid && item_mon.ready)
                expected_steps.push_back(predict_step(item_mon.z_re, item_mon.z_im,
                                                      item_mon.c_re, item_mon.c_im,
                                                      formula_sel));
            if (res_mon.valid && res_mon.ready) begin
                if (expected_steps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: re=%h im=%h",
                                 $realtime, res_mon.next_re, res_mon.next_im);
                end else begin
                    exp_r = expected_steps.pop_front();
                    if (res_mon.next_re !== exp_r.next_re
                            || res_mon.next_im !== exp_r.next_im
                            || res_mon.degenerate !== exp_r.degenerate
                            || res_mon.overflowed !== exp_r.overflowed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp re=%h im=%h dg=%b ov=%b, got re=%h im=%h dg=%b ov=%b",
                                     $realtime, exp_r.next_re, exp_r.next_im,
                                     exp_r.degenerate, exp_r.overflowed,
                                     res_mon.next_re, res_mon.next_im,
                                     res_mon.degenerate, res_mon.overflowed);
                    end
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

/* verif/magnet_fractal_iteration_step_top_tb.sv */
// Testbench top for the magnet iteration step: stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module magnet_fractal_iteration_step_top_tb;

    localparam int             DRAIN_CYCLES = 80;
    localparam int             HOLD_CYCLES  = 1000;
    localparam mfi_pkg::t_word Q1 = 32'sh0100_0000;
    localparam mfi_pkg::t_word Q2 = 32'sh0200_0000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    bit   quiet;
    bit   pressure_go;
    bit   pressure_done;
    int   hold_left;
    int   burst_left;
    bit   burst_stall;

    mfi_item_if item_ch ();
    mfi_cfg_if  cfg_ch ();
    mfi_res_if  res_ch ();

    magnet_fractal_iteration_step_top u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    magnet_fractal_iteration_step_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .item_mon     (item_ch),
        .cfg_mon      (cfg_ch),
        .res_mon      (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // result back-pressure: random bursts, one long hold-off, none at the end
    always @(negedge clk) begin
        if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (quiet) begin
            res_ch.ready <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            res_ch.ready <= !burst_stall;
        end else begin
            burst_stall = ($urandom_range(0, 2) == 0);
            burst_left  = $urandom_range(1, 18) - 1;
            res_ch.ready <= !burst_stall;
        end
    end

    function automatic mfi_pkg::t_word pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return mfi_pkg::t_word'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
            4, 5:       return mfi_pkg::t_word'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            6, 7:       return mfi_pkg::t_word'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return mfi_pkg::WMAX;
                    1:       return mfi_pkg::WMIN;
                    2:       return Q1;
                    3:       return -Q1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // offer one item, with an optional idle burst ahead of it
    task automatic send_point(mfi_pkg::t_word zr, mfi_pkg::t_word zi,
                              mfi_pkg::t_word cr, mfi_pkg::t_word ci);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge clk) item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.z_re  <= zr;
        item_ch.z_im  <= zi;
        item_ch.c_re  <= cr;
        item_ch.c_im  <= ci;
        forever begin
            @(posedge clk);
            if (item_ch.ready) break;
            @(negedge clk);
        end
    endtask

    // drain, then write the formula select while idle
    task automatic set_formula(logic sel);
        @(negedge clk) item_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.formula_select <= sel;
        forever begin
            @(posedge clk);
            if (cfg_ch.ready) break;
        end
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        repeat (count) send_point(pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.z_re          = '0;
        item_ch.z_im          = '0;
        item_ch.c_re          = '0;
        item_ch.c_im          = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.formula_select = 1'b0;
        res_ch.ready          = 1'b1;
        quiet                 = 1'b0;
        pressure_go           = 1'b0;
        pressure_done         = 1'b0;
        hold_left             = 0;
        burst_left            = 0;
        burst_stall           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed, formula 1 (reset setting)
        send_point('0, '0, Q2, '0);              // zero denominator
        send_point('0, '0, '0, '0);
        send_point(Q1, '0, '0, '0);
        send_point(mfi_pkg::WMAX, mfi_pkg::WMAX, mfi_pkg::WMAX, mfi_pkg::WMAX); // saturation
        send_point(mfi_pkg::WMIN, mfi_pkg::WMIN, mfi_pkg::WMIN, mfi_pkg::WMIN);
        send_point(mfi_pkg::WMAX, mfi_pkg::WMIN, mfi_pkg::WMIN, mfi_pkg::WMAX);
        send_point(32'sh0000_0400, '0, Q2, 32'sh0000_0400); // squares round to zero
        send_point(-Q1, Q1, 32'sh0080_0000, -32'sh0080_0000);
        send_point(32'sh0180_0000, -32'sh0040_0000, -Q2, Q1);
        send_point(32'sh0000_0001, 32'sh7fff_0000, 32'sh8000_0001, 32'sh0000_0001);
        send_point(32'shffff_ffff, '0, Q1, '0);

        // directed, formula 2
        set_formula(1'b1);
        send_point('0, '0, 32'sh0180_0000, 32'sd14529496); // near-zero denominator
        send_point('0, '0, '0, '0);
        send_point(Q1, '0, Q1, '0);
        send_point(mfi_pkg::WMAX, mfi_pkg::WMAX, mfi_pkg::WMAX, mfi_pkg::WMAX);
        send_point(mfi_pkg::WMIN, mfi_pkg::WMIN, mfi_pkg::WMIN, mfi_pkg::WMIN);
        send_point(-Q1, Q1, Q2, -Q1);
        send_point(32'sh0040_0000, 32'sh0020_0000, 32'sh0140_0000, 32'sh0010_0000);
        send_point(32'shffff_ffff, 32'sh0000_0001, 32'sh8000_0000, 32'sh7fff_ffff);

        random_phase(220);
        set_formula(1'b0);
        pressure_go = 1'b1;
        random_phase(220);
        set_formula(1'b1);
        random_phase(220);
        set_formula(1'b0);
        quiet = 1'b1;
        random_phase(220);
        @(negedge clk) item_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
